/* hdl/adjacent_merge_min_cost_core_assert.svh */
// Assertion macros for the adjacent merge minimum cost core.
// Used by the top level; depends on nothing else.
`ifndef ADJACENT_MERGE_MIN_COST_CORE_ASSERT_SVH
`define ADJACENT_MERGE_MIN_COST_CORE_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define AMM_ASSERT_IMP(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("adjacent_merge_min_cost_core: assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define AMM_ASSERT_NXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("adjacent_merge_min_cost_core: assertion failed");

`endif

/* hdl/amm_pkg.sv */
// Shared types and constants for the adjacent merge minimum cost core.
// No dependencies; used by amm_cand_unit, the top level and the testbench.
`default_nettype none

package amm_pkg;

    localparam int MAX_SEGMENTS_DEF = 64;
    localparam int LENGTH_BITS_DEF  = 16;
    localparam int SEG_W            = 16;
    localparam int COST_W           = 28;
    localparam logic [COST_W-1:0] COST_MAX = {COST_W{1'b1}};

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PREF,
        ST_SPAN,
        ST_LOOP,
        ST_DRAIN1,
        ST_DRAIN2,
        ST_WRITE,
        ST_OUT
    } amm_state_t;

    typedef struct packed {
        logic init;
        logic issue;
        logic zero_left;
        logic zero_right;
    } amm_cand_ctrl_t;

endpackage

`default_nettype wire

/* hdl/amm_ram.sv */
// Generic RAM: one write port, two read ports with registered read data.
// No dependencies.
`default_nettype none

module amm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr_a,
    input  wire logic [$clog2(DEPTH)-1:0] raddr_b,
    output logic      [WIDTH-1:0]         rdata_a,
    output logic      [WIDTH-1:0]         rdata_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_a <= mem[raddr_a];
        rdata_b <= mem[raddr_b];
    end

endmodule

`default_nettype wire

/* hdl/amm_cand_unit.sv */
// Shared split-candidate unit: saturating add of two interval costs and the span,
// then a running minimum. Depends on amm_pkg.
`default_nettype none

module amm_cand_unit
    import amm_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire amm_cand_ctrl_t    ctrl,
    input  wire logic [COST_W-1:0] left_cost,
    input  wire logic [COST_W-1:0] right_cost,
    input  wire logic [COST_W-1:0] span,
    output logic      [COST_W-1:0] best
);

    logic              v1_reg;
    logic              zl1_reg;
    logic              zr1_reg;
    logic              v2_reg;
    logic [COST_W-1:0] cand_reg;
    logic [COST_W-1:0] cand_next;
    logic [COST_W-1:0] best_reg;
    logic [COST_W-1:0] best_next;
    logic [COST_W+1:0] sum;
    logic [COST_W-1:0] left_eff;
    logic [COST_W-1:0] right_eff;

    always_comb begin
        left_eff  = zl1_reg ? '0 : left_cost;
        right_eff = zr1_reg ? '0 : right_cost;
        sum = (COST_W+2)'(left_eff) + (COST_W+2)'(right_eff) + (COST_W+2)'(span);
        cand_next = (sum > (COST_W+2)'(COST_MAX)) ? COST_MAX : sum[COST_W-1:0];
    end

    always_comb begin
        best_next = best_reg;
        if (ctrl.init) begin
            best_next = COST_MAX;
        end else if (v2_reg && (cand_reg < best_reg)) begin
            best_next = cand_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end else begin
            v1_reg <= ctrl.issue;
            v2_reg <= v1_reg;
        end
        zl1_reg  <= ctrl.zero_left;
        zr1_reg  <= ctrl.zero_right;
        cand_reg <= cand_next;
        best_reg <= best_next;
    end

    assign best = best_reg;

endmodule

`default_nettype wire

/* hdl/adjacent_merge_min_cost_core.sv */
// Adjacent merge minimum cost core: request channels, sequencer and memories.
// Depends on amm_pkg, amm_ram, amm_cand_unit and the assertion macro header.
//
// Usage: each input request carries one segment length; a request with
// s_last_segment set closes the row. Non-final requests are taken one per
// cycle while the core is idle and give no result. The final request starts
// the interval table fill and yields exactly one result request with the
// row's minimum merge cost and the overflow flag (set when more than
// MAX_SEGMENTS segments came in; the extra ones are dropped).
// After the final request the table is filled interval by interval, one
// split point per cycle through the shared candidate unit, fed by the two
// read ports of the interval memory. s_ready is low from the final request
// until the result is passed to the output register. A single segment gives
// cost 0 and skips the table fill.
// Reset clears the row state; the memories need no clearing since every
// entry that is used is written before it is read. A stalled receiver holds
// the result in the output register; new segments are still taken meanwhile,
// and a finished row waits until the output register is free.
`default_nettype none

`include "adjacent_merge_min_cost_core_assert.svh"

module adjacent_merge_min_cost_core
    import amm_pkg::*;
#(
    parameter int MAX_SEGMENTS = MAX_SEGMENTS_DEF,
    parameter int LENGTH_BITS  = LENGTH_BITS_DEF
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_valid,
    output logic                   s_ready,
    input  wire logic [SEG_W-1:0]  s_segment_length,
    input  wire logic              s_last_segment,
    output logic                   m_valid,
    input  wire logic              m_ready,
    output logic      [COST_W-1:0] m_total_cost,
    output logic                   m_overflow
);

    localparam int IDX_W   = $clog2(MAX_SEGMENTS);
    localparam int CNT_W   = $clog2(MAX_SEGMENTS + 1);
    localparam int BW      = CNT_W + 1;
    localparam int LEN_USE = (LENGTH_BITS < SEG_W) ? LENGTH_BITS : SEG_W;
    localparam int PSUM_W  = LEN_USE + IDX_W;
    localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_SEGMENTS);

    amm_state_t        state_reg;
    amm_state_t        state_next;
    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  count_next;
    logic              ovf_reg;
    logic              ovf_next;
    logic [PSUM_W-1:0] sum_reg;
    logic [PSUM_W-1:0] sum_next;
    logic [CNT_W-1:0]  len_reg;
    logic [CNT_W-1:0]  len_next;
    logic [IDX_W-1:0]  a_reg;
    logic [IDX_W-1:0]  a_next;
    logic [IDX_W-1:0]  k_reg;
    logic [IDX_W-1:0]  k_next;
    logic [COST_W-1:0] span_reg;
    logic [COST_W-1:0] span_next;
    logic [COST_W-1:0] result_reg;
    logic [COST_W-1:0] result_next;
    logic              m_valid_reg;
    logic              m_valid_next;
    logic [COST_W-1:0] m_cost_reg;
    logic [COST_W-1:0] m_cost_next;
    logic              m_ovf_reg;
    logic              m_ovf_next;

    logic              accept;
    logic              store;
    logic              out_free;
    logic [PSUM_W-1:0] seg_len;
    logic [PSUM_W-1:0] sum_add;
    logic [BW-1:0]     b_full;
    logic [IDX_W-1:0]  b_idx;
    logic [IDX_W-1:0]  k1;
    logic              row_end;
    logic              table_done;

    logic              pref_we;
    logic [PSUM_W-1:0] pref_b;
    logic [PSUM_W-1:0] pref_a1;
    logic [PSUM_W-1:0] span_diff;
    logic              cost_we;
    logic [COST_W-1:0] cost_left;
    logic [COST_W-1:0] cost_right;
    logic [COST_W-1:0] best;
    amm_cand_ctrl_t    cand_ctrl;

    assign accept     = s_valid && s_ready;
    assign store      = accept && (count_reg < MAX_CNT);
    assign out_free   = !m_valid_reg || m_ready;
    assign seg_len    = PSUM_W'(s_segment_length[LEN_USE-1:0]);
    assign sum_add    = sum_reg + seg_len;
    assign b_full     = BW'(a_reg) + BW'(len_reg) - BW'(1);
    assign b_idx      = b_full[IDX_W-1:0];
    assign k1         = k_reg + IDX_W'(1);
    assign row_end    = CNT_W'(b_idx) == (count_reg - CNT_W'(1));
    assign table_done = row_end && (len_reg == count_reg);
    assign span_diff  = pref_b - ((a_reg == '0) ? '0 : pref_a1);

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept && s_last_segment) begin
                    state_next = (count_reg == '0) ? ST_OUT : ST_PREF;
                end
            end
            ST_PREF:   state_next = ST_SPAN;
            ST_SPAN:   state_next = ST_LOOP;
            ST_LOOP: begin
                if (k1 == b_idx) begin
                    state_next = ST_DRAIN1;
                end
            end
            ST_DRAIN1: state_next = ST_DRAIN2;
            ST_DRAIN2: state_next = ST_WRITE;
            ST_WRITE:  state_next = table_done ? ST_OUT : ST_PREF;
            ST_OUT: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default:   state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        s_ready              = 1'b0;
        pref_we              = 1'b0;
        cost_we              = 1'b0;
        cand_ctrl.init       = 1'b0;
        cand_ctrl.issue      = 1'b0;
        cand_ctrl.zero_left  = k_reg == a_reg;
        cand_ctrl.zero_right = k1 == b_idx;
        unique case (state_reg) inside
            ST_IDLE: begin
                s_ready = 1'b1;
                pref_we = store;
            end
            ST_SPAN:  cand_ctrl.init = 1'b1;
            ST_LOOP:  cand_ctrl.issue = 1'b1;
            ST_WRITE: cost_we = 1'b1;
            ST_PREF, ST_DRAIN1, ST_DRAIN2, ST_OUT: begin
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        count_next   = count_reg;
        ovf_next     = ovf_reg;
        sum_next     = sum_reg;
        len_next     = len_reg;
        a_next       = a_reg;
        k_next       = k_reg;
        span_next    = span_reg;
        result_next  = result_reg;
        m_valid_next = m_valid_reg && !m_ready;
        m_cost_next  = m_cost_reg;
        m_ovf_next   = m_ovf_reg;
        case (state_reg)
            ST_IDLE: begin
                if (store) begin
                    count_next = count_reg + CNT_W'(1);
                    sum_next   = sum_add;
                end else if (accept) begin
                    ovf_next = 1'b1;
                end
                len_next    = CNT_W'(2);
                a_next      = '0;
                result_next = '0;
            end
            ST_SPAN: begin
                span_next = COST_W'(span_diff);
                k_next    = a_reg;
            end
            ST_LOOP: k_next = k1;
            ST_WRITE: begin
                if (row_end) begin
                    len_next = len_reg + CNT_W'(1);
                    a_next   = '0;
                end else begin
                    a_next = a_reg + IDX_W'(1);
                end
                if (table_done) begin
                    result_next = best;
                end
            end
            ST_OUT: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_cost_next  = result_reg;
                    m_ovf_next   = ovf_reg;
                    count_next   = '0;
                    ovf_next     = 1'b0;
                    sum_next     = '0;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            count_reg   <= '0;
            ovf_reg     <= 1'b0;
            sum_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            ovf_reg     <= ovf_next;
            sum_reg     <= sum_next;
            m_valid_reg <= m_valid_next;
        end
        len_reg    <= len_next;
        a_reg      <= a_next;
        k_reg      <= k_next;
        span_reg   <= span_next;
        result_reg <= result_next;
        m_cost_reg <= m_cost_next;
        m_ovf_reg  <= m_ovf_next;
    end

    amm_ram #(
        .WIDTH (PSUM_W),
        .DEPTH (1 << IDX_W)
    ) u_pref_ram (
        .clk     (aclk),
        .we      (pref_we),
        .waddr   (count_reg[IDX_W-1:0]),
        .wdata   (sum_add),
        .raddr_a (b_idx),
        .raddr_b (a_reg - IDX_W'(1)),
        .rdata_a (pref_b),
        .rdata_b (pref_a1)
    );

    amm_ram #(
        .WIDTH (COST_W),
        .DEPTH (1 << (2 * IDX_W))
    ) u_cost_ram (
        .clk     (aclk),
        .we      (cost_we),
        .waddr   ({a_reg, b_idx}),
        .wdata   (best),
        .raddr_a ({a_reg, k_reg}),
        .raddr_b ({k1, b_idx}),
        .rdata_a (cost_left),
        .rdata_b (cost_right)
    );

    amm_cand_unit u_cand (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .ctrl       (cand_ctrl),
        .left_cost  (cost_left),
        .right_cost (cost_right),
        .span       (span_reg),
        .best       (best)
    );

    assign m_valid      = m_valid_reg;
    assign m_total_cost = m_cost_reg;
    assign m_overflow   = m_ovf_reg;

    `AMM_ASSERT_IMP(a_count_bound, aclk, aresetn, 1'b1, count_reg <= MAX_CNT)
    `AMM_ASSERT_IMP(a_ovf_full, aclk, aresetn, ovf_reg, count_reg == MAX_CNT)
    `AMM_ASSERT_IMP(a_split_range, aclk, aresetn, state_reg == ST_LOOP, k_reg < b_idx)
    `AMM_ASSERT_NXT(a_result_out, aclk, aresetn, (state_reg == ST_OUT) && out_free, m_valid_reg && (m_total_cost == $past(result_reg)))

endmodule

`default_nettype wire

/* tb/sv/testbench.sv */
// Self-checking bench for adjacent_merge_min_cost_core: rows of segment lengths in,
// one minimum merge cost per row out, checked against an interval table model.
// Depends on amm_pkg and the core RTL only.
`timescale 1ns / 1ps

module testbench
    import amm_pkg::*;
();

    localparam int TARGET_SEGMENTS = 850;
    localparam int HOLD_CYCLES     = 70000;
    localparam int QUIET_LIMIT     = 400000;
    localparam int SETTLE_CYCLES   = 80;
    localparam int REPORT_LIMIT    = 10;
    localparam logic [SEG_W-1:0] LENGTH_MASK = SEG_W'((64'd1 << LENGTH_BITS_DEF) - 1);

    typedef enum int {
        FILL_MIXED,
        FILL_MAX,
        FILL_ZERO,
        FILL_RAMP
    } row_fill_t;

    typedef struct {
        logic [SEG_W-1:0] length;
        logic             closes_row;
    } segment_req_t;

    typedef struct {
        logic [COST_W-1:0] cost;
        logic              overflow;
    } row_result_t;

    logic              aclk = 1'b0;
    logic              aresetn = 1'b0;
    logic              s_valid = 1'b0;
    logic              s_ready;
    logic [SEG_W-1:0]  s_segment_length = '0;
    logic              s_last_segment = 1'b0;
    logic              m_valid;
    logic              m_ready = 1'b0;
    logic [COST_W-1:0] m_total_cost;
    logic              m_overflow;

    segment_req_t segment_reqs[$];
    row_result_t  expected_rows[$];
    segment_req_t next_req;
    row_result_t  want_row;

    longint unsigned   row_prefix[MAX_SEGMENTS_DEF];
    logic [COST_W-1:0] span_cost[MAX_SEGMENTS_DEF][MAX_SEGMENTS_DEF];
    int                row_segments = 0;
    logic              row_overflow = 1'b0;

    int total_segments = 0;
    int accepted_items = 0;
    int send_gap = 0;
    int stall_left = 0;
    int hold_left = 0;
    logic hold_used = 1'b0;
    int mismatches = 0;
    int quiet_cycles = 0;

    wire calm_phase       = accepted_items + 100 >= total_segments;
    wire may_idle         = ((accepted_items / 60) % 3 != 2) && !calm_phase;
    wire receiver_holding = hold_left > 0;

    adjacent_merge_min_cost_core uut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_segment_length (s_segment_length),
        .s_last_segment   (s_last_segment),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_total_cost     (m_total_cost),
        .m_overflow       (m_overflow)
    );

    always #10 aclk = ~aclk;

    function automatic logic [COST_W-1:0] merge_cost(input int n);
        longint unsigned   span;
        longint unsigned   cand;
        logic [COST_W-1:0] best;
        int                b;
        if (n == 0) begin
            return '0;
        end
        for (int a = 0; a < n; a++) begin
            span_cost[a][a] = '0;
        end
        for (int width = 2; width <= n; width++) begin
            for (int a = 0; a + width <= n; a++) begin
                b = a + width - 1;
                span = row_prefix[b] - (a == 0 ? 64'd0 : row_prefix[a - 1]);
                best = COST_MAX;
                for (int k = a; k < b; k++) begin
                    cand = 64'(span_cost[a][k]) + 64'(span_cost[k + 1][b]) + span;
                    if (cand > 64'(COST_MAX)) begin
                        cand = 64'(COST_MAX);
                    end
                    if (cand < 64'(best)) begin
                        best = cand[COST_W-1:0];
                    end
                end
                span_cost[a][b] = best;
            end
        end
        return span_cost[0][n - 1];
    endfunction

    function automatic logic [SEG_W-1:0] pick_length();
        case ($urandom_range(0, 7))
            0: begin
                return '0;
            end
            1: begin
                return '1;
            end
            2: begin
                return SEG_W'($urandom_range(0, 15));
            end
            default: begin
                return SEG_W'($urandom);
            end
        endcase
    endfunction

    task automatic push_seg(input logic [SEG_W-1:0] length, input logic closes_row);
        segment_req_t req;
        req.length = length;
        req.closes_row = closes_row;
        segment_reqs.push_back(req);
    endtask

    task automatic add_row(input int n, input row_fill_t fill);
        logic [SEG_W-1:0] length;
        for (int i = 0; i < n; i++) begin
            case (fill)
                FILL_MAX: begin
                    length = '1;
                end
                FILL_ZERO: begin
                    length = '0;
                end
                FILL_RAMP: begin
                    length = SEG_W'(i + 1);
                end
                default: begin
                    length = pick_length();
                end
            endcase
            push_seg(length, i == n - 1);
        end
    endtask

    task automatic note_mismatch(input string what, input row_result_t want);
        mismatches++;
        if (mismatches <= REPORT_LIMIT) begin
            $display("%0t: %s: expected cost %0d overflow %0b, got cost %0d overflow %0b",
                     $realtime, what, want.cost, want.overflow, m_total_cost, m_overflow);
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
            s_segment_length <= '0;
            s_last_segment <= 1'b0;
            send_gap <= 0;
        end else begin
            if (s_valid && s_ready) begin
                accepted_items <= accepted_items + 1;
                if (row_segments < MAX_SEGMENTS_DEF) begin
                    row_prefix[row_segments] = (row_segments == 0 ? 64'd0
                        : row_prefix[row_segments - 1]) + 64'(s_segment_length & LENGTH_MASK);
                    row_segments++;
                end else begin
                    row_overflow = 1'b1;
                end
                if (s_last_segment) begin
                    want_row.cost = merge_cost(row_segments);
                    want_row.overflow = row_overflow;
                    expected_rows.push_back(want_row);
                    row_segments = 0;
                    row_overflow = 1'b0;
                end
            end
            if (!s_valid || s_ready) begin
                if (send_gap > 0) begin
                    send_gap <= send_gap - 1;
                    s_valid <= 1'b0;
                end else if (segment_reqs.size() == 0) begin
                    s_valid <= 1'b0;
                end else if (may_idle && !receiver_holding && $urandom_range(0, 7) == 0) begin
                    send_gap <= $urandom_range(0, 18);
                    s_valid <= 1'b0;
                end else begin
                    next_req = segment_reqs.pop_front();
                    s_valid <= 1'b1;
                    s_segment_length <= next_req.length;
                    s_last_segment <= next_req.closes_row;
                end
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
            stall_left <= 0;
            hold_left <= 0;
        end else begin
            if (m_valid && m_ready) begin
                if (expected_rows.size() == 0) begin
                    want_row.cost = '0;
                    want_row.overflow = 1'b0;
                    note_mismatch("result with no open row", want_row);
                end else begin
                    want_row = expected_rows.pop_front();
                    if (m_total_cost !== want_row.cost || m_overflow !== want_row.overflow) begin
                        note_mismatch("row result mismatch", want_row);
                    end
                end
            end
            if (hold_left > 0) begin
                hold_left <= hold_left - 1;
                m_ready <= 1'b0;
            end else if (!hold_used && accepted_items >= 300) begin
                hold_used <= 1'b1;
                hold_left <= HOLD_CYCLES - 1;
                m_ready <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left <= stall_left - 1;
                m_ready <= 1'b0;
            end else if (may_idle && $urandom_range(0, 9) == 0) begin
                stall_left <= $urandom_range(0, 18);
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("[FAIL] regression broken");
                $finish;
            end
        end
    end

    initial begin
        int row_idx;
        row_idx = 0;

        add_row(1, FILL_ZERO);
        add_row(1, FILL_MAX);
        add_row(1, FILL_MIXED);
        add_row(2, FILL_MAX);
        push_seg(16'hFFFF, 1'b0);
        push_seg(16'h0000, 1'b0);
        push_seg(16'hFFFF, 1'b1);
        add_row(4, FILL_ZERO);
        add_row(5, FILL_RAMP);
        push_seg(16'hAAAA, 1'b0);
        push_seg(16'h5555, 1'b1);

        // Full rows and overflowing rows are placed among mostly short rows.
        while (segment_reqs.size() < TARGET_SEGMENTS) begin
            case (row_idx)
                4: begin
                    add_row(MAX_SEGMENTS_DEF, FILL_MAX);
                end
                10: begin
                    add_row(MAX_SEGMENTS_DEF + 1, FILL_MIXED);
                end
                25: begin
                    add_row(MAX_SEGMENTS_DEF, FILL_MIXED);
                end
                40: begin
                    add_row(MAX_SEGMENTS_DEF + 8, FILL_MAX);
                end
                default: begin
                    if ($urandom_range(0, 9) == 0) begin
                        add_row($urandom_range(13, 32), FILL_MIXED);
                    end else begin
                        add_row($urandom_range(1, 12), FILL_MIXED);
                    end
                end
            endcase
            row_idx++;
        end
        total_segments = segment_reqs.size();

        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        while (accepted_items < total_segments || expected_rows.size() != 0) begin
            @(posedge aclk);
        end
        repeat (SETTLE_CYCLES) @(posedge aclk);

        if (mismatches == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
